[hw/rtl/b64d_pkg.sv]
// Package for the streaming Base64 decoder: constants, the result queue depth
// and the character to sextet mapping. No dependencies.
package b64d_pkg;

  localparam int unsigned CntW   = 24;
  localparam int unsigned QDepth = 6;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [CntW-1:0] CntMax  = '1;
  localparam logic [7:0]      PadChar = 8'h3D;

  function automatic logic [5:0] sextet_of(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      v = c - 8'h41;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      v = c - 8'h61 + 8'd26;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30 + 8'd52;
    end else if (c == 8'h2B) begin
      v = 8'd62;
    end else if (c == 8'h2F) begin
      v = 8'd63;
    end
    return v[5:0];
  endfunction

endpackage

[hw/rtl/base64_stream_decoder_top.sv]
// Top level of the streaming Base64 decoder: character assembly, group holding,
// pad trimming and a short result queue. Depends on b64d_pkg.
//
// Usage: characters enter on the input channel (in_valid_i, in_stall_o), one
// per transfer, with in_last_i on the final character of a stream. Decoded
// bytes leave on the output channel (out_valid_o, out_stall_i), one per
// transfer. The limit register max_chars is written through cfg_valid_i and
// cfg_ready_o, which is always high; write it only while the block is idle.
// An input's first result appears in the cycle after its transfer. A character
// that completes a group while an earlier one is held, or that ends a stream,
// queues up to six results, which leave at one per cycle unless the receiver
// stalls. Such a character is stalled while an earlier result is still waiting,
// unless a single one is leaving in that same cycle; other characters are never
// stalled. A group's three bytes are queued by the next group's last character
// and leave during the characters after it, so a plain stream sustains one
// character per cycle unless the receiver stalls; only a stream end may wait.
// When the receiver stalls, the head result holds and the next character that
// queues results waits. Reset empties the queue, clears all stream state and
// sets max_chars to 0. After each stream end all stream state returns to
// reset; max_chars is kept.
module base64_stream_decoder_top
  import b64d_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [CntW-1:0] cfg_max_chars_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      in_char_i,
  input  logic            in_last_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            byte_valid_o,
  output logic            run_last_o,
  output logic            stream_end_o,
  output logic [CntW-1:0] decoded_total_o
);

  logic [CntW-1:0]  max_q;
  logic [1:0]       phase_q, phase_d;
  logic [17:0]      part_q, part_d;
  logic [23:0]      held_q, held_d;
  logic             held_vld_q, held_vld_d;
  logic [1:0]       held_pad_q, held_pad_d;
  logic             cur_pad_q, cur_pad_d;
  logic [CntW-1:0]  seen_q, seen_d;
  logic [CntW-1:0]  emitted_q, emitted_d;

  logic [7:0]       q_byte_q [QDepth];
  logic [7:0]       q_byte_d [QDepth];
  logic [QCntW-1:0] q_cnt_q, q_cnt_d;
  logic             q_marker_q, q_marker_d;
  logic             q_end_q, q_end_d;
  logic [CntW-1:0]  q_total_q, q_total_d;

  logic             take, pad, emit_old, produces, can_load, in_xfer, out_xfer;
  logic [5:0]       sext;
  logic [23:0]      post_held;
  logic             post_vld;
  logic [1:0]       post_pad;
  logic [1:0]       cnt_new;
  logic [2:0]       n_valid;
  logic [CntW:0]    sum;
  logic [CntW-1:0]  emitted_sat;

  assign cfg_ready_o = 1'b1;

  assign take = (max_q == '0) || (seen_q < max_q);
  assign sext = sextet_of(in_char_i);
  assign pad  = (in_char_i == PadChar);

  assign emit_old = take && (phase_q == 2'd3) && held_vld_q;
  assign produces = in_last_i || emit_old;
  assign out_xfer = out_valid_o && !out_stall_i;
  assign can_load = (q_cnt_q == '0) || ((q_cnt_q == QCntW'(1)) && !out_stall_i);
  assign in_stall_o = produces && !can_load;
  assign in_xfer = in_valid_i && !in_stall_o;

  always_comb begin
    post_held = held_q;
    post_vld  = held_vld_q;
    post_pad  = held_pad_q;
    if (take && phase_q == 2'd3) begin
      post_held = {part_q, sext};
      post_vld  = 1'b1;
      post_pad  = {cur_pad_q, pad};
    end
    cnt_new = 2'd3 - {1'b0, post_pad[0]} - {1'b0, post_pad[1]};
    n_valid = emit_old ? 3'd3 : 3'd0;
    if (in_last_i && post_vld) begin
      n_valid = n_valid + {1'b0, cnt_new};
    end
    sum = {1'b0, emitted_q} + (CntW + 1)'(n_valid);
    emitted_sat = sum[CntW] ? CntMax : sum[CntW-1:0];
  end

  always_comb begin
    phase_d    = phase_q;
    part_d     = part_q;
    held_d     = held_q;
    held_vld_d = held_vld_q;
    held_pad_d = held_pad_q;
    cur_pad_d  = cur_pad_q;
    seen_d     = seen_q;
    emitted_d  = emitted_q;
    if (in_xfer) begin
      if (take) begin
        if (seen_q != CntMax) begin
          seen_d = seen_q + CntW'(1);
        end
        phase_d = phase_q + 2'd1;
        case (phase_q)
          2'd0: part_d = {sext, 12'd0};
          2'd1: part_d = {part_q[17:12], sext, 6'd0};
          2'd2: begin
            part_d    = {part_q[17:6], sext};
            cur_pad_d = pad;
          end
          default: begin
            held_d     = post_held;
            held_vld_d = 1'b1;
            held_pad_d = post_pad;
          end
        endcase
      end
      emitted_d = emitted_sat;
      if (in_last_i) begin
        phase_d    = '0;
        part_d     = '0;
        held_d     = '0;
        held_vld_d = 1'b0;
        held_pad_d = '0;
        cur_pad_d  = 1'b0;
        seen_d     = '0;
        emitted_d  = '0;
      end
    end
  end

  always_comb begin
    q_byte_d   = q_byte_q;
    q_cnt_d    = q_cnt_q;
    q_marker_d = q_marker_q;
    q_end_d    = q_end_q;
    q_total_d  = q_total_q;
    if (out_xfer) begin
      for (int i = 0; i < QDepth - 1; i++) begin
        q_byte_d[i] = q_byte_q[i+1];
      end
      q_cnt_d = q_cnt_q - QCntW'(1);
    end
    if (in_xfer && produces) begin
      q_byte_d[0] = emit_old ? held_q[23:16] : post_held[23:16];
      q_byte_d[1] = emit_old ? held_q[15:8]  : post_held[15:8];
      q_byte_d[2] = emit_old ? held_q[7:0]   : post_held[7:0];
      q_byte_d[3] = post_held[23:16];
      q_byte_d[4] = post_held[15:8];
      q_byte_d[5] = post_held[7:0];
      q_cnt_d     = QCntW'(n_valid);
      q_marker_d  = 1'b0;
      q_end_d     = in_last_i;
      q_total_d   = emitted_sat;
      if (n_valid == 3'd0) begin
        q_byte_d[0] = 8'd0;
        q_cnt_d     = QCntW'(1);
        q_marker_d  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q      <= '0;
      phase_q    <= '0;
      part_q     <= '0;
      held_q     <= '0;
      held_vld_q <= 1'b0;
      held_pad_q <= '0;
      cur_pad_q  <= 1'b0;
      seen_q     <= '0;
      emitted_q  <= '0;
      q_cnt_q    <= '0;
      q_marker_q <= 1'b0;
      q_end_q    <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        max_q <= cfg_max_chars_i;
      end
      phase_q    <= phase_d;
      part_q     <= part_d;
      held_q     <= held_d;
      held_vld_q <= held_vld_d;
      held_pad_q <= held_pad_d;
      cur_pad_q  <= cur_pad_d;
      seen_q     <= seen_d;
      emitted_q  <= emitted_d;
      q_cnt_q    <= q_cnt_d;
      q_marker_q <= q_marker_d;
      q_end_q    <= q_end_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_byte_q  <= q_byte_d;
    q_total_q <= q_total_d;
  end

  assign out_valid_o     = (q_cnt_q != '0);
  assign out_byte_o      = q_byte_q[0];
  assign run_last_o      = (q_cnt_q == QCntW'(1));
  assign byte_valid_o    = !(q_marker_q && run_last_o);
  assign stream_end_o    = q_end_q && run_last_o;
  assign decoded_total_o = stream_end_o ? q_total_q : '0;

endmodule
